[rtl/segint_pkg.sv]
// shared constants and types for the segment intersection pipeline
// no dependencies; imported by every module of the block
package segint_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int ORI_COUNT = 4;

  // orientation slots: edge first, then the tested point
  localparam int ORI_ABC = 0;
  localparam int ORI_ABD = 1;
  localparam int ORI_CDA = 2;
  localparam int ORI_CDB = 3;

  typedef struct packed {
    logic shared;
    logic box_a;
    logic box_b;
    logic box_c;
    logic box_d;
  } flags_t;

  typedef struct packed {
    logic [ORI_COUNT-1:0] neg;
    logic [ORI_COUNT-1:0] zero;
  } signs_t;

endpackage

[rtl/segint_prep.sv]
// stage 1: coordinate differences, shared endpoint and bounding box flags
// depends on segint_pkg
module segint_prep #(
  parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] d_x,
  input  logic signed [COORD_WIDTH-1:0] d_y,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [COORD_WIDTH:0]   ex [segint_pkg::ORI_COUNT],
  output logic signed [COORD_WIDTH:0]   ey [segint_pkg::ORI_COUNT],
  output logic signed [COORD_WIDTH:0]   vx [segint_pkg::ORI_COUNT],
  output logic signed [COORD_WIDTH:0]   vy [segint_pkg::ORI_COUNT],
  output segint_pkg::flags_t            flags
);
  import segint_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] ex_next [ORI_COUNT];
  logic signed [DW-1:0] ey_next [ORI_COUNT];
  logic signed [DW-1:0] vx_next [ORI_COUNT];
  logic signed [DW-1:0] vy_next [ORI_COUNT];
  flags_t               flags_next;

  function automatic logic between(input logic signed [COORD_WIDTH-1:0] t,
                                   input logic signed [COORD_WIDTH-1:0] p,
                                   input logic signed [COORD_WIDTH-1:0] q);
    between = (p <= t && t <= q) || (q <= t && t <= p);
  endfunction

  function automatic logic in_box(input logic signed [COORD_WIDTH-1:0] tx,
                                  input logic signed [COORD_WIDTH-1:0] ty,
                                  input logic signed [COORD_WIDTH-1:0] px,
                                  input logic signed [COORD_WIDTH-1:0] py,
                                  input logic signed [COORD_WIDTH-1:0] qx,
                                  input logic signed [COORD_WIDTH-1:0] qy);
    in_box = between(tx, px, qx) && between(ty, py, qy);
  endfunction

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    ex_next[ORI_ABC] = DW'(b_x) - DW'(a_x);
    ey_next[ORI_ABC] = DW'(b_y) - DW'(a_y);
    vx_next[ORI_ABC] = DW'(c_x) - DW'(a_x);
    vy_next[ORI_ABC] = DW'(c_y) - DW'(a_y);
    ex_next[ORI_ABD] = DW'(b_x) - DW'(a_x);
    ey_next[ORI_ABD] = DW'(b_y) - DW'(a_y);
    vx_next[ORI_ABD] = DW'(d_x) - DW'(a_x);
    vy_next[ORI_ABD] = DW'(d_y) - DW'(a_y);
    ex_next[ORI_CDA] = DW'(d_x) - DW'(c_x);
    ey_next[ORI_CDA] = DW'(d_y) - DW'(c_y);
    vx_next[ORI_CDA] = DW'(a_x) - DW'(c_x);
    vy_next[ORI_CDA] = DW'(a_y) - DW'(c_y);
    ex_next[ORI_CDB] = DW'(d_x) - DW'(c_x);
    ey_next[ORI_CDB] = DW'(d_y) - DW'(c_y);
    vx_next[ORI_CDB] = DW'(b_x) - DW'(c_x);
    vy_next[ORI_CDB] = DW'(b_y) - DW'(c_y);

    flags_next.shared = (a_x == c_x && a_y == c_y) || (a_x == d_x && a_y == d_y) ||
                        (b_x == c_x && b_y == c_y) || (b_x == d_x && b_y == d_y);
    flags_next.box_a  = in_box(a_x, a_y, c_x, c_y, d_x, d_y);
    flags_next.box_b  = in_box(b_x, b_y, c_x, c_y, d_x, d_y);
    flags_next.box_c  = in_box(c_x, c_y, a_x, a_y, b_x, b_y);
    flags_next.box_d  = in_box(d_x, d_y, a_x, a_y, b_x, b_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ex    <= ex_next;
      ey    <= ey_next;
      vx    <= vx_next;
      vy    <= vy_next;
      flags <= flags_next;
    end
  end

endmodule

[rtl/segint_mult.sv]
// stage 2: the two products of each cross product
// depends on segint_pkg
module segint_mult #(
  parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic signed [COORD_WIDTH:0]     ex [segint_pkg::ORI_COUNT],
  input  logic signed [COORD_WIDTH:0]     ey [segint_pkg::ORI_COUNT],
  input  logic signed [COORD_WIDTH:0]     vx [segint_pkg::ORI_COUNT],
  input  logic signed [COORD_WIDTH:0]     vy [segint_pkg::ORI_COUNT],
  input  segint_pkg::flags_t              up_flags,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic signed [2*COORD_WIDTH+1:0] pl [segint_pkg::ORI_COUNT],
  output logic signed [2*COORD_WIDTH+1:0] pr [segint_pkg::ORI_COUNT],
  output segint_pkg::flags_t              flags
);
  import segint_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [PW-1:0] pl_next [ORI_COUNT];
  logic signed [PW-1:0] pr_next [ORI_COUNT];

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    for (int k = 0; k < ORI_COUNT; k++) begin
      pl_next[k] = PW'(ex[k]) * PW'(vy[k]);
      pr_next[k] = PW'(ey[k]) * PW'(vx[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pl    <= pl_next;
      pr    <= pr_next;
      flags <= up_flags;
    end
  end

endmodule

[rtl/segint_sign.sv]
// stage 3: cross product differences reduced to sign and zero bits
// depends on segint_pkg
module segint_sign #(
  parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic signed [2*COORD_WIDTH+1:0] pl [segint_pkg::ORI_COUNT],
  input  logic signed [2*COORD_WIDTH+1:0] pr [segint_pkg::ORI_COUNT],
  input  segint_pkg::flags_t              up_flags,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output segint_pkg::signs_t              signs,
  output segint_pkg::flags_t              flags
);
  import segint_pkg::*;

  localparam int XW = 2 * COORD_WIDTH + 3;

  logic signed [XW-1:0] cprod [ORI_COUNT];
  signs_t               signs_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    for (int k = 0; k < ORI_COUNT; k++) begin
      cprod[k]           = XW'(pl[k]) - XW'(pr[k]);
      signs_next.neg[k]  = cprod[k][XW-1];
      signs_next.zero[k] = (cprod[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      signs <= signs_next;
      flags <= up_flags;
    end
  end

endmodule

[rtl/segment_intersection_test_core.sv]
// segment intersection test, top level: four register stages and the decision
// depends on segint_pkg, segint_prep, segint_mult, segint_sign
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------
//   segment | seg_valid, seg_stall | a_x a_y b_x b_y c_x c_y d_x d_y
//   result  | hit_valid, hit_stall | intersects
//
// one item per cycle while the result is not stalled
// stages: differences and box flags, products, cross sign, decision register
// each stage holds its item while the next stage cannot take it, so bubbles close up
// seg_stall rises only when every stage holds an item and the result waits
// rst is synchronous and clears the stage valid bits only
module segment_intersection_test_core #(
  parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seg_valid,
  output logic                          seg_stall,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] d_x,
  input  logic signed [COORD_WIDTH-1:0] d_y,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic                          intersects
);
  import segint_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic                 prep_ready;
  logic                 prep_valid;
  logic signed [DW-1:0] ex [ORI_COUNT];
  logic signed [DW-1:0] ey [ORI_COUNT];
  logic signed [DW-1:0] vx [ORI_COUNT];
  logic signed [DW-1:0] vy [ORI_COUNT];
  flags_t               prep_flags;

  logic                 mult_ready;
  logic                 mult_valid;
  logic signed [PW-1:0] pl [ORI_COUNT];
  logic signed [PW-1:0] pr [ORI_COUNT];
  flags_t               mult_flags;

  logic                 sign_ready;
  logic                 sign_valid;
  signs_t               signs;
  flags_t               sign_flags;

  logic                 hit_ready;
  logic                 proper;
  logic                 touch;
  logic                 intersects_next;

  segint_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (seg_valid),
    .up_ready (prep_ready),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .c_x      (c_x),
    .c_y      (c_y),
    .d_x      (d_x),
    .d_y      (d_y),
    .dn_valid (prep_valid),
    .dn_ready (mult_ready),
    .ex       (ex),
    .ey       (ey),
    .vx       (vx),
    .vy       (vy),
    .flags    (prep_flags)
  );

  segint_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prep_valid),
    .up_ready (mult_ready),
    .ex       (ex),
    .ey       (ey),
    .vx       (vx),
    .vy       (vy),
    .up_flags (prep_flags),
    .dn_valid (mult_valid),
    .dn_ready (sign_ready),
    .pl       (pl),
    .pr       (pr),
    .flags    (mult_flags)
  );

  segint_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mult_valid),
    .up_ready (sign_ready),
    .pl       (pl),
    .pr       (pr),
    .up_flags (mult_flags),
    .dn_valid (sign_valid),
    .dn_ready (hit_ready),
    .signs    (signs),
    .flags    (sign_flags)
  );

  assign seg_stall = !prep_ready;
  assign hit_ready = !hit_valid || !hit_stall;

  always_comb begin
    proper = !signs.zero[ORI_ABC] && !signs.zero[ORI_ABD] &&
             (signs.neg[ORI_ABC] != signs.neg[ORI_ABD]) &&
             !signs.zero[ORI_CDA] && !signs.zero[ORI_CDB] &&
             (signs.neg[ORI_CDA] != signs.neg[ORI_CDB]);
    // endpoint collinear with the other segment and inside its box
    touch  = (signs.zero[ORI_CDA] && sign_flags.box_a) ||
             (signs.zero[ORI_CDB] && sign_flags.box_b) ||
             (signs.zero[ORI_ABC] && sign_flags.box_c) ||
             (signs.zero[ORI_ABD] && sign_flags.box_d);
    intersects_next = sign_flags.shared || proper || touch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (hit_ready) begin
      hit_valid <= sign_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_ready && sign_valid) begin
      intersects <= intersects_next;
    end
  end

`ifndef SYNTHESIS
  a_empty_front_takes: assert property (@(posedge clk) disable iff (rst)
    !prep_valid |-> !seg_stall)
    else $error("segment stalled with empty first stage");

  a_shared_hits: assert property (@(posedge clk) disable iff (rst)
    (sign_valid && hit_ready && sign_flags.shared) |=> (hit_valid && intersects))
    else $error("shared endpoint not reported as hit");

  a_crossing_hits: assert property (@(posedge clk) disable iff (rst)
    (sign_valid && hit_ready && proper) |=> (hit_valid && intersects))
    else $error("proper crossing not reported as hit");

  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    (sign_valid && hit_ready && !sign_flags.shared && !proper && !touch)
      |=> (hit_valid && !intersects))
    else $error("disjoint segments reported as hit");
`endif

endmodule
